/* rtl/core/vrl_pkg.sv */
// vrl_pkg: types, register indexes, fixed limits and pipeline depths for the
// velocity ramp and limit block. No dependencies.
package vrl_pkg;

    typedef logic signed [15:0] q412_t;
    typedef logic signed [16:0] lim17_t;
    typedef logic [3:0]         cfg_idx_t;

    // Register indexes of the configuration port
    localparam cfg_idx_t REG_MIN_VEL_X       = 4'd0;
    localparam cfg_idx_t REG_MAX_VEL_X       = 4'd1;
    localparam cfg_idx_t REG_MAX_VEL_THETA   = 4'd2;
    localparam cfg_idx_t REG_ACC_LIM_X       = 4'd3;
    localparam cfg_idx_t REG_DECEL_LIM_X     = 4'd4;
    localparam cfg_idx_t REG_ACC_LIM_THETA   = 4'd5;
    localparam cfg_idx_t REG_DECEL_LIM_THETA = 4'd6;
    localparam cfg_idx_t REG_PLANAR_CAP      = 4'd7;

    // Fixed y-axis limits and minimum speeds, Q4.12
    localparam lim17_t Y_VEL_LO        = 17'sd0;
    localparam lim17_t Y_VEL_HI        = 17'sd0;
    localparam lim17_t Y_ACCEL         = 17'sd0;
    localparam lim17_t Y_DECEL         = 17'sd0;
    localparam logic [14:0] PLANAR_FLOOR    = 15'd0;
    localparam logic [15:0] TURN_FLOOR      = 16'd0;
    localparam logic [31:0] PLANAR_FLOOR_SQ = 32'(PLANAR_FLOOR) * 32'(PLANAR_FLOOR);

    // Per-axis limits handed to one lane
    typedef struct packed {
        lim17_t acc;
        lim17_t dec;
        lim17_t lo;
        lim17_t hi;
    } lane_lim_t;

    localparam int LANE_DEPTH   = 3;
    localparam int SQRT_STEPS   = 24;
    localparam int DIV_STEPS    = 16;
    localparam int PLANAR_DEPTH = 4 + SQRT_STEPS + DIV_STEPS;
    localparam int PIPE_DEPTH   = LANE_DEPTH + PLANAR_DEPTH;

endpackage

/* rtl/core/vrl_in_if.sv */
// vrl_in_if: input channel carrying commanded and current velocities and dt.
// No dependencies.
interface vrl_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cmd_x;
    logic signed [15:0] cmd_y;
    logic signed [15:0] cmd_theta;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_theta;
    logic        [15:0] dt;

    modport source (output valid, cmd_x, cmd_y, cmd_theta, start_x, start_y,
                    start_theta, dt, input ready);
    modport sink   (input valid, cmd_x, cmd_y, cmd_theta, start_x, start_y,
                    start_theta, dt, output ready);
endinterface

/* rtl/core/vrl_out_if.sv */
// vrl_out_if: result channel carrying the limited velocities.
// No dependencies.
interface vrl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic signed [15:0] new_theta;

    modport source (output valid, new_x, new_y, new_theta, input ready);
    modport sink   (input valid, new_x, new_y, new_theta, output ready);
endinterface

/* rtl/core/vrl_cfg_if.sv */
// vrl_cfg_if: configuration write channel (register index and data).
// No dependencies.
interface vrl_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/velocity_ramp_and_limit.sv */
// velocity_ramp_and_limit: pipelined ramp and limit from accepted word to result word.
// Throughput one word per cycle; the pipeline advances whenever its last stage
// is empty or its result word is taken, so input and output stall together.
// Reset clears the stage valid bits and loads the limit registers with their
// defaults. Depends on vrl_pkg, vrl_*_if, vrl_axis_lane and vrl_planar.
module velocity_ramp_and_limit (
    input  logic       clk,
    input  logic       rst_n,
    vrl_in_if.sink     cmd,
    vrl_out_if.source  res,
    vrl_cfg_if.sink    cfg
);
    import vrl_pkg::*;

    // Limit registers
    q412_t       min_vel_x_reg;
    q412_t       max_vel_x_reg;
    logic [14:0] max_vel_theta_reg;
    logic [14:0] acc_lim_x_reg;
    q412_t       decel_lim_x_reg;
    logic [14:0] acc_lim_theta_reg;
    q412_t       decel_lim_theta_reg;
    logic [14:0] planar_cap_reg;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  en;

    lane_lim_t lim_x, lim_y, lim_th;
    q412_t     lane_x, lane_y, lane_th;

    // Configuration writes are taken whenever out of reset; unknown indexes drop the word
    assign cfg.ready = rst_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_vel_x_reg       <= -16'sd4096;
            max_vel_x_reg       <= 16'sd4096;
            max_vel_theta_reg   <= 15'd4096;
            acc_lim_x_reg       <= 15'd4096;
            decel_lim_x_reg     <= 16'sd0;
            acc_lim_theta_reg   <= 15'd4096;
            decel_lim_theta_reg <= 16'sd0;
            planar_cap_reg      <= 15'd0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MIN_VEL_X:       min_vel_x_reg       <= cfg.data;
                REG_MAX_VEL_X:       max_vel_x_reg       <= cfg.data;
                REG_MAX_VEL_THETA:   max_vel_theta_reg   <= cfg.data[14:0];
                REG_ACC_LIM_X:       acc_lim_x_reg       <= cfg.data[14:0];
                REG_DECEL_LIM_X:     decel_lim_x_reg     <= cfg.data;
                REG_ACC_LIM_THETA:   acc_lim_theta_reg   <= cfg.data[14:0];
                REG_DECEL_LIM_THETA: decel_lim_theta_reg <= cfg.data;
                REG_PLANAR_CAP:      planar_cap_reg      <= cfg.data[14:0];
                default:             ;
            endcase
        end
    end

    // Advance the whole pipeline unless the result word is stalled; hold off in reset
    assign en        = !vld_reg[PIPE_DEPTH-1] || res.ready;
    assign cmd.ready = en && rst_n;
    assign res.valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], cmd.valid};
    end

    // Per-axis limits; theta is clamped symmetrically
    always_comb
    begin
        lim_x.acc  = 17'(signed'({1'b0, acc_lim_x_reg}));
        lim_x.dec  = 17'(decel_lim_x_reg);
        lim_x.lo   = 17'(min_vel_x_reg);
        lim_x.hi   = 17'(max_vel_x_reg);
        lim_y.acc  = Y_ACCEL;
        lim_y.dec  = Y_DECEL;
        lim_y.lo   = Y_VEL_LO;
        lim_y.hi   = Y_VEL_HI;
        lim_th.acc = 17'(signed'({1'b0, acc_lim_theta_reg}));
        lim_th.dec = 17'(decel_lim_theta_reg);
        lim_th.lo  = -17'(signed'({1'b0, max_vel_theta_reg}));
        lim_th.hi  = 17'(signed'({1'b0, max_vel_theta_reg}));
    end

    // Three ramp-and-clamp lanes side by side
    vrl_axis_lane u_lane_x (
        .clk    (clk),
        .en     (en),
        .start  (cmd.start_x),
        .cmd    (cmd.cmd_x),
        .dt     (cmd.dt),
        .lim    (lim_x),
        .result (lane_x)
    );

    vrl_axis_lane u_lane_y (
        .clk    (clk),
        .en     (en),
        .start  (cmd.start_y),
        .cmd    (cmd.cmd_y),
        .dt     (cmd.dt),
        .lim    (lim_y),
        .result (lane_y)
    );

    vrl_axis_lane u_lane_th (
        .clk    (clk),
        .en     (en),
        .start  (cmd.start_theta),
        .cmd    (cmd.cmd_theta),
        .dt     (cmd.dt),
        .lim    (lim_th),
        .result (lane_th)
    );

    // Merge: planar ceiling and minimum speeds
    vrl_planar u_planar (
        .clk    (clk),
        .en     (en),
        .x      (lane_x),
        .y      (lane_y),
        .th     (lane_th),
        .maxs   (planar_cap_reg),
        .res_x  (res.new_x),
        .res_y  (res.new_y),
        .res_th (res.new_theta)
    );

endmodule

/* rtl/core/vrl_axis_lane.sv */
// vrl_axis_lane: three-stage ramp and clamp of one velocity axis.
// Depends on vrl_pkg.
module vrl_axis_lane (
    input  logic              clk,
    input  logic              en,
    input  vrl_pkg::q412_t    start,
    input  vrl_pkg::q412_t    cmd,
    input  logic [15:0]       dt,
    input  vrl_pkg::lane_lim_t lim,
    output vrl_pkg::q412_t    result
);
    import vrl_pkg::*;

    logic               up;
    lim17_t             dec_eff;
    lim17_t             sel;
    logic [16:0]        mag;
    logic [31:0]        prod;

    logic [15:0]        step_reg;
    logic               neg_reg;
    logic               up_reg;
    q412_t              start_reg;
    q412_t              cmd_reg;

    logic signed [17:0] sum;
    q412_t              sat;
    q412_t              ramp;
    q412_t              ramp_reg;

    lim17_t             lo;
    lim17_t             hi;
    lim17_t             mclip;
    lim17_t             clip;
    q412_t              result_reg;

    // Stage 1: pick the rate limit and scale it by dt
    always_comb
    begin
        up      = start < cmd;
        dec_eff = ($signed(lim.dec) == 17'sd0) ? -$signed(lim.acc) : $signed(lim.dec);
        sel     = up ? $signed(lim.acc) : dec_eff;
        mag     = sel[16] ? 17'(-sel) : 17'(sel);
        prod    = 32'(mag) * 32'(dt);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg  <= prod[31:16];
            neg_reg   <= sel[16];
            up_reg    <= up;
            start_reg <= start;
            cmd_reg   <= cmd;
        end
    end

    // Stage 2: saturating add, never past the command
    always_comb
    begin
        sum = neg_reg ? 18'(start_reg) - $signed({2'b00, step_reg})
                      : 18'(start_reg) + $signed({2'b00, step_reg});
        if (sum > 18'sd32767)
            sat = 16'sh7fff;
        else if (sum < -18'sd32768)
            sat = 16'sh8000;
        else
            sat = sum[15:0];
        if (up_reg)
            ramp = (sat < cmd_reg) ? sat : cmd_reg;
        else
            ramp = (sat > cmd_reg) ? sat : cmd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ramp_reg <= ramp;
    end

    // Stage 3: clamp; crossed limits give the lower limit
    always_comb
    begin
        lo    = $signed(lim.lo);
        hi    = $signed(lim.hi);
        mclip = (17'(ramp_reg) < hi) ? 17'(ramp_reg) : hi;
        clip  = (mclip > lo) ? mclip : lo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= clip[15:0];
    end

    assign result = result_reg;

endmodule

/* rtl/core/vrl_planar.sv */
// vrl_planar: merging stage; planar speed ceiling through a pipelined square
// root and two pipelined dividers, then minimum-speed zeroing. Depends on vrl_pkg.
module vrl_planar (
    input  logic           clk,
    input  logic           en,
    input  vrl_pkg::q412_t x,
    input  vrl_pkg::q412_t y,
    input  vrl_pkg::q412_t th,
    input  logic [14:0]    maxs,
    output vrl_pkg::q412_t res_x,
    output vrl_pkg::q412_t res_y,
    output vrl_pkg::q412_t res_th
);
    import vrl_pkg::*;

    typedef struct packed {
        q412_t x;
        q412_t y;
        q412_t th;
        logic  scale;
        logic  small_xy;
    } carry_t;

    logic signed [31:0] xx;
    logic signed [31:0] yy;
    q412_t       x0_reg, y0_reg, th0_reg;
    logic [31:0] xx0_reg, yy0_reg;
    logic [29:0] ms0_reg;
    logic [31:0] m2;

    logic [47:0] sv_reg [0:SQRT_STEPS];
    logic [47:0] sr_reg [0:SQRT_STEPS];
    carry_t      sc_reg [0:SQRT_STEPS];
    logic [47:0] sv_next [0:SQRT_STEPS-1];
    logic [47:0] sr_next [0:SQRT_STEPS-1];

    logic [16:0] magx, magy;
    logic [39:0] dx_reg [0:DIV_STEPS];
    logic [39:0] dy_reg [0:DIV_STEPS];
    logic [15:0] qx_reg [0:DIV_STEPS];
    logic [15:0] qy_reg [0:DIV_STEPS];
    logic [23:0] dr_reg [0:DIV_STEPS];
    carry_t      dc_reg [0:DIV_STEPS];
    logic [39:0] dx_next [0:DIV_STEPS-1];
    logic [39:0] dy_next [0:DIV_STEPS-1];
    logic [15:0] qx_next [0:DIV_STEPS-1];
    logic [15:0] qy_next [0:DIV_STEPS-1];

    carry_t      fc;
    q412_t       fx, fy, fth;
    logic [16:0] th_abs;
    q412_t       ox_reg, oy_reg, oth_reg;

    // Squares of the clamped axes and of the ceiling
    always_comb
    begin
        xx = x * x;
        yy = y * y;
        m2 = xx0_reg + yy0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg  <= x;
            y0_reg  <= y;
            th0_reg <= th;
            xx0_reg <= 32'(xx);
            yy0_reg <= 32'(yy);
            ms0_reg <= 30'(maxs) * 30'(maxs);
        end
    end

    // Square root, one result bit per stage
    always_comb
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            if (sv_reg[k] >= sr_reg[k] + (48'd1 << (2 * (SQRT_STEPS - 1 - k))))
            begin
                sv_next[k] = sv_reg[k] - (sr_reg[k] + (48'd1 << (2 * (SQRT_STEPS - 1 - k))));
                sr_next[k] = (sr_reg[k] >> 1) + (48'd1 << (2 * (SQRT_STEPS - 1 - k)));
            end
            else
            begin
                sv_next[k] = sv_reg[k];
                sr_next[k] = sr_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Magnitude and decisions, enter the root pipeline
            sv_reg[0]          <= {m2, 16'd0};
            sr_reg[0]          <= 48'd0;
            sc_reg[0].x        <= x0_reg;
            sc_reg[0].y        <= y0_reg;
            sc_reg[0].th       <= th0_reg;
            sc_reg[0].scale    <= (maxs != 15'd0) && (m2 > {2'b00, ms0_reg});
            sc_reg[0].small_xy <= m2 < PLANAR_FLOOR_SQ;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                sv_reg[k+1] <= sv_next[k];
                sr_reg[k+1] <= sr_next[k];
                sc_reg[k+1] <= sc_reg[k];
            end
        end
    end

    // Numerators |v| * speed ceiling * 256
    always_comb
    begin
        magx = sc_reg[SQRT_STEPS].x[15] ? 17'(-17'(sc_reg[SQRT_STEPS].x))
                                         : 17'(sc_reg[SQRT_STEPS].x);
        magy = sc_reg[SQRT_STEPS].y[15] ? 17'(-17'(sc_reg[SQRT_STEPS].y))
                                         : 17'(sc_reg[SQRT_STEPS].y);
    end

    // Restoring division, one quotient bit per stage, both axes side by side
    always_comb
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            dx_next[j] = dx_reg[j];
            dy_next[j] = dy_reg[j];
            qx_next[j] = qx_reg[j];
            qy_next[j] = qy_reg[j];
            if (dx_reg[j] >= (40'(dr_reg[j]) << (DIV_STEPS - 1 - j)))
            begin
                dx_next[j] = dx_reg[j] - (40'(dr_reg[j]) << (DIV_STEPS - 1 - j));
                qx_next[j][DIV_STEPS - 1 - j] = 1'b1;
            end
            if (dy_reg[j] >= (40'(dr_reg[j]) << (DIV_STEPS - 1 - j)))
            begin
                dy_next[j] = dy_reg[j] - (40'(dr_reg[j]) << (DIV_STEPS - 1 - j));
                qy_next[j][DIV_STEPS - 1 - j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg[0] <= {1'b0, 31'(magx) * 31'(maxs), 8'd0};
            dy_reg[0] <= {1'b0, 31'(magy) * 31'(maxs), 8'd0};
            qx_reg[0] <= 16'd0;
            qy_reg[0] <= 16'd0;
            dr_reg[0] <= sr_reg[SQRT_STEPS][23:0];
            dc_reg[0] <= sc_reg[SQRT_STEPS];
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                dx_reg[j+1] <= dx_next[j];
                dy_reg[j+1] <= dy_next[j];
                qx_reg[j+1] <= qx_next[j];
                qy_reg[j+1] <= qy_next[j];
                dr_reg[j+1] <= dr_reg[j];
                dc_reg[j+1] <= dc_reg[j];
            end
        end
    end

    // Select scaled values and apply the minimum speeds
    always_comb
    begin
        fc     = dc_reg[DIV_STEPS];
        fx     = fc.x;
        fy     = fc.y;
        fth    = fc.th;
        if (fc.scale)
        begin
            fx = fc.x[15] ? -$signed(qx_reg[DIV_STEPS]) : $signed(qx_reg[DIV_STEPS]);
            fy = fc.y[15] ? -$signed(qy_reg[DIV_STEPS]) : $signed(qy_reg[DIV_STEPS]);
        end
        if (fc.small_xy)
        begin
            fx = 16'sd0;
            fy = 16'sd0;
        end
        th_abs = fc.th[15] ? 17'(-17'(fc.th)) : 17'(fc.th);
        if ((TURN_FLOOR != 16'd0) && (th_abs < 17'(TURN_FLOOR)))
            fth = 16'sd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg  <= fx;
            oy_reg  <= fy;
            oth_reg <= fth;
        end
    end

    assign res_x  = ox_reg;
    assign res_y  = oy_reg;
    assign res_th = oth_reg;

endmodule
